// File: design/dhlt_pkg.sv
// shared widths, item types and cordic constants for the dh link transform
package dhlt_pkg;

    // field widths of the input and result items
    localparam int ANGLE_BITS    = 16;
    localparam int LENGTH_BITS   = 32;
    localparam int CORDIC_STAGES = 16;
    localparam int ROT_BITS      = 16;

    // internal q30 widths: angles up to 4 rad, vector magnitude below 2 in q30
    localparam int Z_W          = 34;
    localparam int TRIG_W       = 32;
    localparam int ZSHIFT       = 33 - ANGLE_BITS;
    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);

    localparam logic signed [TRIG_W-1:0] GAIN_Q30    = 32'sd652032874;
    localparam logic signed [Z_W-1:0]    PI_Q30      = 34'sd3373259426;
    localparam logic signed [Z_W-1:0]    HALF_PI_Q30 = 34'sd1686629713;

    // truncated arctangent of 2^-i in q30
    localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
        32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
        32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    // one link's parameters
    typedef struct packed {
        logic signed [ANGLE_BITS-1:0]  joint_angle;
        logic signed [ANGLE_BITS-1:0]  twist_angle;
        logic signed [LENGTH_BITS-1:0] link_length;
        logic signed [LENGTH_BITS-1:0] link_offset;
    } t_in_item;

    // link transform without the constant entries
    typedef struct packed {
        logic signed [ROT_BITS-1:0]    r00;
        logic signed [ROT_BITS-1:0]    r01;
        logic signed [ROT_BITS-1:0]    r02;
        logic signed [ROT_BITS-1:0]    r10;
        logic signed [ROT_BITS-1:0]    r11;
        logic signed [ROT_BITS-1:0]    r12;
        logic signed [ROT_BITS-1:0]    r21;
        logic signed [ROT_BITS-1:0]    r22;
        logic signed [LENGTH_BITS-1:0] pos_x;
        logic signed [LENGTH_BITS-1:0] pos_y;
        logic signed [LENGTH_BITS-1:0] pos_z;
    } t_out_item;

    // one cordic vector with its residual angle and quadrant flip
    typedef struct packed {
        logic signed [TRIG_W-1:0] x;
        logic signed [TRIG_W-1:0] y;
        logic signed [Z_W-1:0]    z;
        logic                     flip;
    } t_rot;

    // word handed from cell to cell
    typedef struct packed {
        logic                          vld;
        t_rot                          th;
        t_rot                          al;
        logic signed [LENGTH_BITS-1:0] len;
        logic signed [LENGTH_BITS-1:0] off;
    } t_stage;

endpackage

// File: design/dh_link_transform_unit.sv
// top level of the denavit-hartenberg link transform pipeline
//
// usage:
//   an item (joint angle, twist angle, link length, link offset) is taken at
//   each rising edge with i_start high and o_busy low. o_busy is always low,
//   so an item may be offered in every cycle.
//   the result item (rotation entries in q2.14, translation in q16.16) is on
//   o_result for exactly one cycle, marked by o_valid, and is taken at the
//   edge that ends that cycle; the receiver has no way to hold it off.
// throughput and pipeline:
//   one item per cycle. an item passes one angle reduction stage, one cell
//   per cordic micro-rotation, then quadrant fix-up, multiply and rounding
//   stages.
//   the row of cordic cells sets the latency; every stage is a single register.
// reset:
//   i_rst_n low clears all valid flags, dropping items in flight; no result
//   strobes until new items arrive. there is no other state.
module dh_link_transform_unit import dhlt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_in_item  i_item,
    output logic      o_busy,
    output logic      o_valid,
    output t_out_item o_result
);

    logic   w_accept;
    t_stage r_entry;
    t_stage n_entry;
    t_stage w_chain [CORDIC_STAGES+1];

    // widen to q30 and fold into +-pi/2, remembering the sign flip
    function automatic t_rot reduce(input logic signed [ANGLE_BITS-1:0] ang);
        t_rot                  r;
        logic signed [Z_W-1:0] z;
        z      = Z_W'(ang);
        z      = z <<< ZSHIFT;
        r.x    = GAIN_Q30;
        r.y    = '0;
        r.flip = 1'b0;
        if (z > HALF_PI_Q30) begin
            r.z    = z - PI_Q30;
            r.flip = 1'b1;
        end else if (z < -HALF_PI_Q30) begin
            r.z    = z + PI_Q30;
            r.flip = 1'b1;
        end else begin
            r.z = z;
        end
        return r;
    endfunction

    assign o_busy   = 1'b0;
    assign w_accept = i_start & ~o_busy;

    // entry stage
    always_comb begin
        n_entry.vld = w_accept;
        n_entry.th  = reduce(i_item.joint_angle);
        n_entry.al  = reduce(i_item.twist_angle);
        n_entry.len = i_item.link_length;
        n_entry.off = i_item.link_offset;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.vld <= 1'b0;
        end else begin
            r_entry.vld <= n_entry.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry.th  <= n_entry.th;
        r_entry.al  <= n_entry.al;
        r_entry.len <= n_entry.len;
        r_entry.off <= n_entry.off;
    end

    assign w_chain[0] = r_entry;

    // row of cordic cells, one micro-rotation each
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        dhlt_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (ATAN_IDX_W'(g)),
            .i_data  (w_chain[g]),
            .o_data  (w_chain[g+1])
        );
    end

    // products and output register
    dhlt_prod u_prod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (w_chain[CORDIC_STAGES]),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

// File: design/dhlt_cordic_cell.sv
// one cordic micro-rotation cell, rotating the joint and twist vectors together
module dhlt_cordic_cell import dhlt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [ATAN_IDX_W-1:0] i_stage,
    input  t_stage                i_data,
    output t_stage                o_data
);

    t_stage r_data;
    t_stage n_data;

    // rotate by +-atan(2^-s), direction from the sign of the residual angle
    function automatic t_rot rot_step(input t_rot v, input logic [ATAN_IDX_W-1:0] s);
        t_rot                     r;
        logic signed [TRIG_W-1:0] vx;
        logic signed [TRIG_W-1:0] vy;
        logic signed [TRIG_W-1:0] xs;
        logic signed [TRIG_W-1:0] ys;
        logic signed [Z_W-1:0]    ang;
        r   = v;
        vx  = v.x;
        vy  = v.y;
        xs  = vx >>> s;
        ys  = vy >>> s;
        ang = Z_W'(ATAN_Q30[s]);
        if (!v.z[Z_W-1]) begin
            r.x = vx - ys;
            r.y = vy + xs;
            r.z = v.z - ang;
        end else begin
            r.x = vx + ys;
            r.y = vy - xs;
            r.z = v.z + ang;
        end
        return r;
    endfunction

    // next cell word
    always_comb begin
        n_data    = i_data;
        n_data.th = rot_step(i_data.th, i_stage);
        n_data.al = rot_step(i_data.al, i_stage);
    end

    // item valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data.vld <= 1'b0;
        end else begin
            r_data.vld <= n_data.vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_data.th  <= n_data.th;
        r_data.al  <= n_data.al;
        r_data.len <= n_data.len;
        r_data.off <= n_data.off;
    end

    assign o_data = r_data;

endmodule

// File: design/dhlt_prod.sv
// quadrant fix-up, products and rounding of the cordic outputs into the result item
module dhlt_prod import dhlt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_stage    i_data,
    output logic      o_valid,
    output t_out_item o_result
);

    localparam int RW      = LENGTH_BITS + TRIG_W + 1;
    localparam int SH_TRIG = 30 - (ROT_BITS - 2);
    localparam int SH_ROT  = 60 - (ROT_BITS - 2);
    localparam int SH_LEN  = 30;

    // fixed-up trig values
    logic                          r_f_vld;
    logic signed [TRIG_W-1:0]      r_st, r_ct, r_sa, r_ca;
    logic signed [LENGTH_BITS-1:0] r_f_len, r_f_off;

    // products
    logic                             r_m_vld;
    logic signed [2*TRIG_W-1:0]       r_p_cast, r_p_sast, r_p_cact, r_p_sact;
    logic signed [LENGTH_BITS+TRIG_W-1:0] r_p_lct, r_p_lst;
    logic signed [TRIG_W-1:0]         r_m_st, r_m_ct, r_m_sa, r_m_ca;
    logic signed [LENGTH_BITS-1:0]    r_m_off;

    // result
    logic      r_valid;
    t_out_item r_result;
    t_out_item n_result;

    // divide by 2^s rounding half away from zero
    function automatic logic signed [RW-1:0] round_shift(input logic signed [RW-1:0] v,
                                                         input int s);
        logic signed [RW-1:0] h;
        logic signed [RW-1:0] sum;
        h   = RW'(1) <<< (s - 1);
        sum = v + (v[RW-1] ? h - RW'(1) : h);
        return sum >>> s;
    endfunction

    function automatic logic signed [ROT_BITS-1:0] sat_rot(input logic signed [RW-1:0] q);
        logic [RW-ROT_BITS:0] top;
        top = q[RW-1:ROT_BITS-1];
        if ((&top) || !(|top)) begin
            return q[ROT_BITS-1:0];
        end
        return q[RW-1] ? {1'b1, {(ROT_BITS-1){1'b0}}} : {1'b0, {(ROT_BITS-1){1'b1}}};
    endfunction

    function automatic logic signed [LENGTH_BITS-1:0] sat_len(input logic signed [RW-1:0] q);
        logic [RW-LENGTH_BITS:0] top;
        top = q[RW-1:LENGTH_BITS-1];
        if ((&top) || !(|top)) begin
            return q[LENGTH_BITS-1:0];
        end
        return q[RW-1] ? {1'b1, {(LENGTH_BITS-1){1'b0}}} : {1'b0, {(LENGTH_BITS-1){1'b1}}};
    endfunction

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
            r_m_vld <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_f_vld <= i_data.vld;
            r_m_vld <= r_f_vld;
            r_valid <= r_m_vld;
        end
    end

    // undo the half-turn reduction
    always_ff @(posedge i_clk) begin
        r_ct    <= i_data.th.flip ? -i_data.th.x : i_data.th.x;
        r_st    <= i_data.th.flip ? -i_data.th.y : i_data.th.y;
        r_ca    <= i_data.al.flip ? -i_data.al.x : i_data.al.x;
        r_sa    <= i_data.al.flip ? -i_data.al.y : i_data.al.y;
        r_f_len <= i_data.len;
        r_f_off <= i_data.off;
    end

    // full precision products
    always_ff @(posedge i_clk) begin
        r_p_cast <= r_ca * r_st;
        r_p_sast <= r_sa * r_st;
        r_p_cact <= r_ca * r_ct;
        r_p_sact <= r_sa * r_ct;
        r_p_lct  <= r_f_len * r_ct;
        r_p_lst  <= r_f_len * r_st;
        r_m_st   <= r_st;
        r_m_ct   <= r_ct;
        r_m_sa   <= r_sa;
        r_m_ca   <= r_ca;
        r_m_off  <= r_f_off;
    end

    // rounding and saturation into the result formats
    always_comb begin
        n_result.r00   = sat_rot(round_shift(RW'(r_m_ct), SH_TRIG));
        n_result.r01   = -sat_rot(round_shift(RW'(r_p_cast), SH_ROT));
        n_result.r02   = sat_rot(round_shift(RW'(r_p_sast), SH_ROT));
        n_result.r10   = sat_rot(round_shift(RW'(r_m_st), SH_TRIG));
        n_result.r11   = sat_rot(round_shift(RW'(r_p_cact), SH_ROT));
        n_result.r12   = -sat_rot(round_shift(RW'(r_p_sact), SH_ROT));
        n_result.r21   = sat_rot(round_shift(RW'(r_m_sa), SH_TRIG));
        n_result.r22   = sat_rot(round_shift(RW'(r_m_ca), SH_TRIG));
        n_result.pos_x = sat_len(round_shift(RW'(r_p_lct), SH_LEN));
        n_result.pos_y = sat_len(round_shift(RW'(r_p_lst), SH_LEN));
        n_result.pos_z = r_m_off;
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
